// ===== hw/rtl/tbo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_pkg
// shared types and result codes for the triangle / square cell overlap unit
// ----------------------------------------------------------------------------
package tbo_pkg;

    localparam int CW = 31;   // input coordinate width
    localparam int HW = 30;   // half cell size width
    localparam int VW = 32;   // cell bounds and triangle edge vectors
    localparam int DW = 33;   // corner minus vertex
    localparam int PW = 65;   // edge x relative products

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [CW-1:0]        size_t;

    typedef enum logic [2:0] {
        DEC_APART  = 3'd0,
        DEC_HOLDS  = 3'd1,
        DEC_CORNER = 3'd2,
        DEC_CROSS  = 3'd3,
        DEC_NONE   = 3'd4
    } decide_t;

    // edge e: 0 = a-b, 1 = a-c, 2 = b-c; corner k: 0 tl, 1 tr, 2 bl, 3 br
    typedef struct packed {
        logic [2:0][1:0][VW-1:0]      edge_v;
        logic [2:0][3:0][1:0][DW-1:0] rel;
        logic                         apart;
        logic                         holds;
        logic [2:0][3:0]              axis_x;
    } geom_t;

    typedef struct packed {
        logic            apart;
        logic            holds;
        logic [2:0][3:0] axis_x;
    } flags_t;

    typedef struct packed {
        logic [2:0][3:0] pos;
        logic [2:0][3:0] neg;
    } signs_t;

endpackage

`default_nettype wire

// ===== hw/rtl/triangle_box_overlap_2d_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_box_overlap_2d_unit
// overlap test of a 2d triangle against a square cell of programmable size
// ----------------------------------------------------------------------------
// an accepted start passes through the prep, orient and decide stages before the done strobe
// throughput: one beat per cycle, set by the five register stages
// busy is always low: the result side cannot stall the pipeline
// reset clears the valid chain and sets cell_size to 1.0 (Q15.16)
module triangle_box_overlap_2d_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire tbo_pkg::coord_t tri_a_x,
    input  wire tbo_pkg::coord_t tri_a_y,
    input  wire tbo_pkg::coord_t tri_b_x,
    input  wire tbo_pkg::coord_t tri_b_y,
    input  wire tbo_pkg::coord_t tri_c_x,
    input  wire tbo_pkg::coord_t tri_c_y,
    input  wire tbo_pkg::coord_t cell_center_x,
    input  wire tbo_pkg::coord_t cell_center_y,
    input  wire logic            cfg_we,
    input  wire tbo_pkg::size_t  cfg_wdata,
    output logic                 done,
    output logic                 overlaps,
    output logic [2:0]           decided_by
);
    import tbo_pkg::*;

    size_t  cell_size_reg;
    logic   accept;
    logic   v2;
    logic   v4;
    geom_t  geom;
    flags_t flags;
    signs_t signs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_size_reg <= size_t'(65536);
        else if (cfg_we)
            cell_size_reg <= cfg_wdata;
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    tbo_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .tri_a_x       (tri_a_x),
        .tri_a_y       (tri_a_y),
        .tri_b_x       (tri_b_x),
        .tri_b_y       (tri_b_y),
        .tri_c_x       (tri_c_x),
        .tri_c_y       (tri_c_y),
        .cell_center_x (cell_center_x),
        .cell_center_y (cell_center_y),
        .half          (cell_size_reg[CW-1:1]),
        .out_valid     (v2),
        .geom          (geom)
    );

    tbo_orient u_orient (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .geom      (geom),
        .out_valid (v4),
        .flags     (flags),
        .signs     (signs)
    );

    tbo_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v4),
        .flags      (flags),
        .signs      (signs),
        .done       (done),
        .overlaps   (overlaps),
        .decided_by (decided_by)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tbo_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_prep
// input capture, cell bounds, box tests, edge and corner vectors
// ----------------------------------------------------------------------------
module tbo_prep (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire tbo_pkg::coord_t tri_a_x,
    input  wire tbo_pkg::coord_t tri_a_y,
    input  wire tbo_pkg::coord_t tri_b_x,
    input  wire tbo_pkg::coord_t tri_b_y,
    input  wire tbo_pkg::coord_t tri_c_x,
    input  wire tbo_pkg::coord_t tri_c_y,
    input  wire tbo_pkg::coord_t cell_center_x,
    input  wire tbo_pkg::coord_t cell_center_y,
    input  wire logic [tbo_pkg::HW-1:0] half,
    output logic                 out_valid,
    output tbo_pkg::geom_t       geom
);
    import tbo_pkg::*;

    coord_t          tx_reg [3];
    coord_t          ty_reg [3];
    coord_t          cx_reg;
    coord_t          cy_reg;
    logic [HW-1:0]   h_reg;
    logic            v1_reg;
    logic            v2_reg;
    geom_t           geom_reg;
    geom_t           geom_next;

    logic signed [VW-1:0] vx [3];
    logic signed [VW-1:0] vy [3];
    logic signed [VW-1:0] vminx, vmaxx, vminy, vmaxy;
    logic signed [VW-1:0] tminx, tmaxx, tminy, tmaxy;
    logic signed [VW-1:0] kx [4];
    logic signed [VW-1:0] ky [4];
    logic signed [VW-1:0] lvl [4];
    logic                 h_nz;

    function automatic logic opp(input logic signed [VW-1:0] a,
                                 input logic signed [VW-1:0] b,
                                 input logic signed [VW-1:0] l);
        return ((a < l) && (b > l)) || ((a > l) && (b < l));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg[0] <= tri_a_x;
        ty_reg[0] <= tri_a_y;
        tx_reg[1] <= tri_b_x;
        ty_reg[1] <= tri_b_y;
        tx_reg[2] <= tri_c_x;
        ty_reg[2] <= tri_c_y;
        cx_reg    <= cell_center_x;
        cy_reg    <= cell_center_y;
        h_reg     <= half;
        geom_reg  <= geom_next;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = VW'(tx_reg[i]);
            vy[i] = VW'(ty_reg[i]);
        end
        h_nz  = (h_reg != '0);
        vminx = VW'(cx_reg) - $signed({2'b00, h_reg});
        vmaxx = VW'(cx_reg) + $signed({2'b00, h_reg});
        vminy = VW'(cy_reg) - $signed({2'b00, h_reg});
        vmaxy = VW'(cy_reg) + $signed({2'b00, h_reg});

        tminx = vx[0]; tmaxx = vx[0];
        tminy = vy[0]; tmaxy = vy[0];
        for (int i = 1; i < 3; i++)
        begin
            if (vx[i] < tminx) tminx = vx[i];
            if (vx[i] > tmaxx) tmaxx = vx[i];
            if (vy[i] < tminy) tminy = vy[i];
            if (vy[i] > tmaxy) tmaxy = vy[i];
        end

        kx[0] = vminx; ky[0] = vmaxy;
        kx[1] = vmaxx; ky[1] = vmaxy;
        kx[2] = vminx; ky[2] = vminy;
        kx[3] = vmaxx; ky[3] = vminy;
        // cell edges: top, left, bottom, right
        lvl[0] = vmaxy; lvl[1] = vminx; lvl[2] = vminy; lvl[3] = vmaxx;

        geom_next.apart = (tminx > vmaxx) || (tminy > vmaxy) ||
                          (tmaxx < vminx) || (tmaxy < vminy);
        geom_next.holds = (tminx >= vminx) && (tmaxx <= vmaxx) &&
                          (tminy >= vminy) && (tmaxy <= vmaxy);

        geom_next.edge_v[0][0] = vx[1] - vx[0];
        geom_next.edge_v[0][1] = vy[1] - vy[0];
        geom_next.edge_v[1][0] = vx[2] - vx[0];
        geom_next.edge_v[1][1] = vy[2] - vy[0];
        geom_next.edge_v[2][0] = vx[2] - vx[1];
        geom_next.edge_v[2][1] = vy[2] - vy[1];

        for (int k = 0; k < 4; k++)
        begin
            geom_next.rel[0][k][0] = DW'(kx[k]) - DW'(vx[0]);
            geom_next.rel[0][k][1] = DW'(ky[k]) - DW'(vy[0]);
            geom_next.rel[1][k][0] = DW'(kx[k]) - DW'(vx[0]);
            geom_next.rel[1][k][1] = DW'(ky[k]) - DW'(vy[0]);
            geom_next.rel[2][k][0] = DW'(kx[k]) - DW'(vx[1]);
            geom_next.rel[2][k][1] = DW'(ky[k]) - DW'(vy[1]);
        end

        geom_next.axis_x[0][0] = h_nz && opp(vy[0], vy[1], lvl[0]);
        geom_next.axis_x[0][1] = h_nz && opp(vx[0], vx[1], lvl[1]);
        geom_next.axis_x[0][2] = h_nz && opp(vy[0], vy[1], lvl[2]);
        geom_next.axis_x[0][3] = h_nz && opp(vx[0], vx[1], lvl[3]);
        geom_next.axis_x[1][0] = h_nz && opp(vy[0], vy[2], lvl[0]);
        geom_next.axis_x[1][1] = h_nz && opp(vx[0], vx[2], lvl[1]);
        geom_next.axis_x[1][2] = h_nz && opp(vy[0], vy[2], lvl[2]);
        geom_next.axis_x[1][3] = h_nz && opp(vx[0], vx[2], lvl[3]);
        geom_next.axis_x[2][0] = h_nz && opp(vy[1], vy[2], lvl[0]);
        geom_next.axis_x[2][1] = h_nz && opp(vx[1], vx[2], lvl[1]);
        geom_next.axis_x[2][2] = h_nz && opp(vy[1], vy[2], lvl[2]);
        geom_next.axis_x[2][3] = h_nz && opp(vx[1], vx[2], lvl[3]);
    end

    assign out_valid = v2_reg;
    assign geom      = geom_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tbo_orient.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_orient
// orientation of each cell corner against each triangle edge
// ----------------------------------------------------------------------------
module tbo_orient (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire tbo_pkg::geom_t geom,
    output logic                out_valid,
    output tbo_pkg::flags_t     flags,
    output tbo_pkg::signs_t     signs
);
    import tbo_pkg::*;

    logic [2:0][3:0][1:0][PW-1:0] prod_reg;
    logic [2:0][3:0][1:0][PW-1:0] prod_next;
    flags_t f3_reg;
    flags_t f4_reg;
    signs_t s_reg;
    signs_t s_next;
    logic   v3_reg;
    logic   v4_reg;

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_next[e][k][0] = PW'($signed(geom.edge_v[e][0]) *
                                         $signed(geom.rel[e][k][1]));
                prod_next[e][k][1] = PW'($signed(geom.edge_v[e][1]) *
                                         $signed(geom.rel[e][k][0]));
            end
        end
    end

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s_next.pos[e][k] = $signed(prod_reg[e][k][0]) > $signed(prod_reg[e][k][1]);
                s_next.neg[e][k] = $signed(prod_reg[e][k][0]) < $signed(prod_reg[e][k][1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        f3_reg   <= '{apart: geom.apart, holds: geom.holds, axis_x: geom.axis_x};
        f4_reg   <= f3_reg;
        s_reg    <= s_next;
    end

    assign out_valid = v4_reg;
    assign flags     = f4_reg;
    assign signs     = s_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tbo_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_decide
// ordered tests: boxes apart, box holds, corner inside, edge crossing
// ----------------------------------------------------------------------------
module tbo_decide (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire tbo_pkg::flags_t flags,
    input  wire tbo_pkg::signs_t signs,
    output logic                 done,
    output logic                 overlaps,
    output logic [2:0]           decided_by
);
    import tbo_pkg::*;

    logic    done_reg;
    logic    ovl_reg;
    logic    ovl_next;
    decide_t dec_reg;
    decide_t dec_next;
    logic [3:0] corner_in;
    logic       crossing;
    logic [1:0] ca [4];
    logic [1:0] cb [4];

    always_comb
    begin
        // corner pairs of the cell edges: top, left, bottom, right
        ca[0] = 2'd0; cb[0] = 2'd1;
        ca[1] = 2'd0; cb[1] = 2'd2;
        ca[2] = 2'd2; cb[2] = 2'd3;
        ca[3] = 2'd1; cb[3] = 2'd3;
        for (int k = 0; k < 4; k++)
        begin
            corner_in[k] = !((signs.pos[0][k] && signs.pos[1][k]) ||
                             (signs.neg[0][k] && signs.neg[1][k]) ||
                             (signs.pos[2][k] && signs.neg[0][k]) ||
                             (signs.neg[2][k] && signs.pos[0][k]));
        end
        crossing = 1'b0;
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (flags.axis_x[e][k] &&
                    ((signs.pos[e][ca[k]] && signs.neg[e][cb[k]]) ||
                     (signs.neg[e][ca[k]] && signs.pos[e][cb[k]])))
                    crossing = 1'b1;
            end
        end
        if (flags.apart)
            dec_next = DEC_APART;
        else if (flags.holds)
            dec_next = DEC_HOLDS;
        else if (|corner_in)
            dec_next = DEC_CORNER;
        else if (crossing)
            dec_next = DEC_CROSS;
        else
            dec_next = DEC_NONE;
        ovl_next = (dec_next == DEC_HOLDS) || (dec_next == DEC_CORNER) ||
                   (dec_next == DEC_CROSS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        ovl_reg <= ovl_next;
        dec_reg <= dec_next;
    end

    assign done       = done_reg;
    assign overlaps   = ovl_reg;
    assign decided_by = dec_reg;

    a_ovl_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (overlaps == ((decided_by == DEC_HOLDS) ||
                  (decided_by == DEC_CORNER) || (decided_by == DEC_CROSS))))
        else $error("overlap flag disagrees with code");
    a_apart_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && flags.apart) |=> (decided_by == DEC_APART))
        else $error("apart boxes not reported first");
    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> done)
        else $error("beat lost");
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |=> !done)
        else $error("spurious beat");

endmodule

`default_nettype wire
